@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define CPDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CPDR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CPDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cpdr_pkg.sv @@
// Constants, types and helpers of the card presence dedup reporter.
package cpdr_pkg;

    localparam int CAPACITY = 16;
    localparam int BUCKETS  = 64;

    localparam int ID_W   = 16;
    localparam int ST_W   = 8;
    localparam int BYTE_W = 8;
    localparam int HASH_W = 6;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENT_W  = ID_W + ST_W;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
    localparam logic [BYTE_W-1:0] PROTO_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] SLEEP_CMD  = 8'h01;
    localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0d;
    localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0a;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ST_W-1:0] st;
    } entry_t;

    // (id & 0x3f) % BUCKETS; BUCKETS is a power of two no larger than 64
    function automatic logic [HASH_W-1:0] bucket_of(input logic [ID_W-1:0] id);
        return id[HASH_W-1:0] & HASH_W'(BUCKETS - 1);
    endfunction

endpackage

@@ hw/rtl/cpdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cpdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/card_presence_dedup_reporter_top.sv @@
// Top level of the card presence dedup reporter: table control, frame builder, output register.
//
//  channel  | dir | tdata (low bit up)                          | tuser     | tlast
//  s_axis   | in  | card_id, tag_status, random_byte, check_byte | command   | -
//  m_axis   | out | data_byte, reply_id                          | kind      | last
//
// Table entries sit in one RAM (one read and one write port, registered read data).
// Packet: on accept, stored entries are read and compared in turn, and the packet is appended
// when none matches and there is room; a bad check or random field is dropped on accept. Tick
// on n entries over d distinct buckets: 3 header beats, d + 1 passes over the RAM, 3 beats per
// entry, 3 trailer beats. A stalled master side holds the frame builder on the pending beat.
// Reset clears state, count and output valid; RAM contents are never read beyond the count.
module card_presence_dedup_reporter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // card_id[15:0], tag_status[23:16],
                                       // random_byte[31:24], check_byte[39:32]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // data_byte[7:0], reply_id[23:8]
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast   // last
);

    localparam int CW = cpdr_pkg::CNT_W;
    localparam int AW = cpdr_pkg::ADDR_W;
    localparam int HW = cpdr_pkg::HASH_W;
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] CAP_CNT = CW'(cpdr_pkg::CAPACITY);
    localparam logic [1:0]    SEL_END = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LK_RD  = 8'b0000_0010,
        ST_LK_CHK = 8'b0000_0100,
        ST_HDR    = 8'b0000_1000,
        ST_SC_RD  = 8'b0001_0000,
        ST_SC_CHK = 8'b0010_0000,
        ST_ENT    = 8'b0100_0000,
        ST_TRL    = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [1:0]              sel_reg, sel_next;
    logic [HW-1:0]           cur_reg, cur_next;
    logic [HW-1:0]           nxt_reg, nxt_next;
    logic                    nf_reg, nf_next;
    logic                    first_reg, first_next;
    logic [7:0]              xr_reg, xr_next;
    logic [15:0]             pid_reg, pid_next;
    logic [7:0]              pst_reg, pst_next;
    cpdr_pkg::entry_t        ent_reg, ent_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    logic [7:0]              out_data_reg, out_data_next;
    logic [15:0]             out_rid_reg, out_rid_next;
    logic                    out_last_reg, out_last_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    cpdr_pkg::entry_t        ram_wdata, ram_rdata;

    logic                    out_free, s_fire, pkt_ok, idx_last, do_adv;
    logic                    emit, emit_kind, emit_last;
    logic [7:0]              emit_data;
    logic [15:0]             emit_rid;
    logic [HW-1:0]           bkt, nxt_c;
    logic                    nf_c;
    logic [7:0]              count_byte;

    logic        in_cmd;
    logic [15:0] in_id;
    logic [7:0]  in_st, in_rnd, in_chk;

    assign in_cmd = s_axis_tuser;
    assign in_id  = s_axis_tdata[15:0];
    assign in_st  = s_axis_tdata[23:16];
    assign in_rnd = s_axis_tdata[31:24];
    assign in_chk = s_axis_tdata[39:32];

    assign pkt_ok = (in_chk == (in_rnd ^ in_st ^ in_id[7:0] ^ in_id[15:8]))
                    && (in_rnd[7:1] == 7'd0);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign idx_last      = (idx_reg + ONE) == cnt_reg;
    assign count_byte    = 8'(cnt_reg);
    assign bkt           = cpdr_pkg::bucket_of(ram_rdata.id);

    cpdr_ram #(
        .WIDTH (cpdr_pkg::ENT_W),
        .DEPTH (cpdr_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        sel_next   = sel_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        nf_next    = nf_reg;
        first_next = first_reg;
        xr_next    = xr_reg;
        pid_next   = pid_reg;
        pst_next   = pst_reg;
        ent_next   = ent_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[AW-1:0];

        emit      = 1'b0;
        emit_kind = cpdr_pkg::KIND_FRAME;
        emit_data = '0;
        emit_rid  = '0;
        emit_last = 1'b0;

        nf_c   = nf_reg;
        nxt_c  = nxt_reg;
        do_adv = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (in_cmd == cpdr_pkg::CMD_TICK)
                    begin
                        if (cnt_reg != '0)
                        begin
                            state_next = ST_HDR;
                            sel_next   = '0;
                            xr_next    = '0;
                            first_next = 1'b1;
                        end
                    end
                    else if (pkt_ok)
                    begin
                        emit       = 1'b1;
                        emit_kind  = cpdr_pkg::KIND_REPLY;
                        emit_data  = cpdr_pkg::SLEEP_CMD;
                        emit_rid   = in_id;
                        emit_last  = 1'b1;
                        pid_next   = in_id;
                        pst_next   = in_st;
                        idx_next   = '0;
                        state_next = ST_LK_RD;
                    end
                end
            end
            ST_LK_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    // no match: append while there is room
                    if (cnt_reg < CAP_CNT)
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = cnt_reg[AW-1:0];
                        ram_wdata.id = pid_reg;
                        ram_wdata.st = pst_reg;
                        cnt_next     = cnt_reg + ONE;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LK_CHK;
                end
            end
            ST_LK_CHK:
            begin
                if (ram_rdata.id == pid_reg)
                begin
                    ram_we       = 1'b1;
                    ram_wdata.id = pid_reg;
                    ram_wdata.st = ram_rdata.st | pst_reg;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ONE;
                    state_next = ST_LK_RD;
                end
            end
            ST_HDR:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (sel_reg)
                        2'd0:    emit_data = cpdr_pkg::SYNC_BYTE;
                        2'd1:    emit_data = cpdr_pkg::PROTO_BYTE;
                        default: emit_data = count_byte;
                    endcase
                    xr_next = xr_reg ^ emit_data;
                    if (sel_reg == SEL_END)
                    begin
                        sel_next   = '0;
                        idx_next   = '0;
                        nf_next    = 1'b0;
                        state_next = ST_SC_RD;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK:
            begin
                // track the smallest bucket above the one being drained (any bucket on the first pass)
                if ((first_reg || (bkt > cur_reg)) && (!nf_reg || (bkt < nxt_reg)))
                begin
                    nf_c  = 1'b1;
                    nxt_c = bkt;
                end
                nf_next  = nf_c;
                nxt_next = nxt_c;
                if (!first_reg && (bkt == cur_reg))
                begin
                    ent_next   = ram_rdata;
                    sel_next   = '0;
                    state_next = ST_ENT;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            ST_ENT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (sel_reg)
                        2'd0:    emit_data = ent_reg.st;
                        2'd1:    emit_data = ent_reg.id[15:8];
                        default: emit_data = ent_reg.id[7:0];
                    endcase
                    xr_next = xr_reg ^ emit_data;
                    if (sel_reg == SEL_END)
                    begin
                        do_adv = 1'b1;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            ST_TRL:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    case (sel_reg)
                        2'd0:    emit_data = xr_reg;
                        2'd1:    emit_data = cpdr_pkg::CR_BYTE;
                        default: emit_data = cpdr_pkg::LF_BYTE;
                    endcase
                    if (sel_reg == SEL_END)
                    begin
                        emit_last  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // next entry, next bucket pass, or trailer
        if (do_adv)
        begin
            if (!idx_last)
            begin
                idx_next   = idx_reg + ONE;
                state_next = ST_SC_RD;
            end
            else if (nf_c)
            begin
                cur_next   = nxt_c;
                first_next = 1'b0;
                nf_next    = 1'b0;
                idx_next   = '0;
                state_next = ST_SC_RD;
            end
            else
            begin
                sel_next   = '0;
                state_next = ST_TRL;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_rid_next   = out_rid_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_data_next  = emit_data;
            out_rid_next   = emit_rid;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        sel_reg      <= sel_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        nf_reg       <= nf_next;
        first_reg    <= first_next;
        xr_reg       <= xr_next;
        pid_reg      <= pid_next;
        pst_reg      <= pst_next;
        ent_reg      <= ent_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_rid_reg  <= out_rid_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rid_reg, out_data_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ hw/rtl/cpdr_checker.sv @@
// Port-level checks of the card presence dedup reporter, bound to its top level.
`include "assert_macros.svh"

module cpdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic        out_stall;
    logic [25:0] out_beat;
    logic        reply_beat;
    logic        reply_ok;
    logic        frame_beat;
    logic [15:0] reply_rid;
    logic [15:0] in_id;
    logic        good_pkt;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_beat   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign reply_beat = m_axis_tvalid && (m_axis_tuser == cpdr_pkg::KIND_REPLY);
    assign reply_ok   = m_axis_tlast && (m_axis_tdata[7:0] == cpdr_pkg::SLEEP_CMD);
    assign frame_beat = m_axis_tvalid && (m_axis_tuser == cpdr_pkg::KIND_FRAME);
    assign reply_rid  = m_axis_tdata[23:8];
    assign in_id      = s_axis_tdata[15:0];

    // packet beat taken with a good check and random field
    assign good_pkt = s_axis_tvalid && s_axis_tready
                      && (s_axis_tuser == cpdr_pkg::CMD_PACKET)
                      && (s_axis_tdata[31:25] == 7'd0)
                      && (s_axis_tdata[39:32] == (s_axis_tdata[31:24] ^ s_axis_tdata[23:16]
                                                 ^ s_axis_tdata[15:8] ^ s_axis_tdata[7:0]));

    // a stalled beat holds
    `CPDR_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(out_beat), "stall not held")

    // a sleep reply is a single beat carrying the sleep command
    `CPDR_ASSERT_IMPL(a_reply_form, reply_beat, reply_ok, "malformed sleep reply")

    // frame beats carry no reply id
    `CPDR_ASSERT_IMPL(a_frame_rid, frame_beat, reply_rid == 16'd0, "frame beat with reply id")

    // no new item enters while a frame is still being sent
    `CPDR_ASSERT(a_frame_blocks, !(frame_beat && !m_axis_tlast && s_axis_tready), "ready mid-frame")

    // a good packet is answered next cycle with its own id
    `CPDR_ASSERT_NEXT(a_rid, good_pkt, reply_beat && (reply_rid == $past(in_id)), "bad reply id")

endmodule

bind card_presence_dedup_reporter_top cpdr_checker u_cpdr_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for the dedup reporter: stream driver, monitor, table model.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF       = 6;
    localparam int MAX_WAIT       = 17;
    localparam int RANDOM_ITEMS   = 160;
    localparam int RX_HOLD_CYCLES = 320;
    localparam int HOLD_AFTER     = 70;
    // worst quiet stretch: full-table tick scan (17 passes over 16 entries) plus a long hold
    localparam int WDOG_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 700;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic        cmd;
        logic [15:0] id;
        logic [7:0]  st;
        logic [7:0]  rnd;
        logic [7:0]  chk;
        int          gap;
    } tag_item_t;

    typedef struct {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] rid;
        logic        last;
    } out_beat_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // card_id, tag_status, random_byte, check_byte
    logic        s_axis_tuser  = 1'b0; // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // data_byte, reply_id
    logic        m_axis_tuser;         // kind
    logic        m_axis_tlast;

    card_presence_dedup_reporter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // stimulus and expectations
    tag_item_t   tag_items[$];
    out_beat_t   due_beats[$];
    int          items_total    = 0;
    int          items_accepted = 0;
    int          err_cnt        = 0;
    int          idle_cycles    = 0;
    int          out_seen       = 0;
    logic        in_beat_taken  = 1'b0;
    logic        out_beat_taken = 1'b0;
    logic        rx_hold_on     = 1'b0;

    // table model
    logic [15:0] tag_ids[cpdr_pkg::CAPACITY];
    logic [7:0]  tag_states[cpdr_pkg::CAPACITY];
    int          tag_count = 0;
    logic [7:0]  frame_xor;

    function automatic tag_item_t make_pkt(logic [15:0] id, logic [7:0] st, logic [7:0] rnd);
        tag_item_t it;
        it.cmd = cpdr_pkg::CMD_PACKET;
        it.id  = id;
        it.st  = st;
        it.rnd = rnd;
        it.chk = rnd ^ st ^ id[7:0] ^ id[15:8];
        it.gap = 0;
        return it;
    endfunction

    function automatic tag_item_t make_tick();
        tag_item_t it;
        it.cmd = cpdr_pkg::CMD_TICK;
        it.id  = 16'($urandom);
        it.st  = 8'($urandom);
        it.rnd = 8'($urandom);
        it.chk = 8'($urandom);
        it.gap = 0;
        return it;
    endfunction

    // runs of back-to-back items between randomly gapped ones
    task automatic queue_item(tag_item_t it);
        it.gap = (items_total % 48 < 14) ? 0 : int'($urandom_range(0, MAX_WAIT));
        tag_items.push_back(it);
        items_total++;
    endtask

    task automatic push_beat(logic kind, logic [7:0] data, logic [15:0] rid, logic last);
        out_beat_t b;
        b.kind = kind;
        b.data = data;
        b.rid  = rid;
        b.last = last;
        due_beats.push_back(b);
        if (kind == cpdr_pkg::KIND_FRAME)
            frame_xor = frame_xor ^ data;
    endtask

    task automatic tag_table_step(tag_item_t it);
        logic hit;
        int   n;
        if (it.cmd == cpdr_pkg::CMD_PACKET) begin
            if (it.chk != (it.rnd ^ it.st ^ it.id[7:0] ^ it.id[15:8]) || it.rnd > 8'd1)
                return;
            push_beat(cpdr_pkg::KIND_REPLY, cpdr_pkg::SLEEP_CMD, it.id, 1'b1);
            hit = 1'b0;
            for (int i = 0; i < tag_count; i++) begin
                if (!hit && tag_ids[i] == it.id) begin
                    tag_states[i] = tag_states[i] | it.st;
                    hit = 1'b1;
                end
            end
            if (!hit && tag_count < cpdr_pkg::CAPACITY) begin
                tag_ids[tag_count]    = it.id;
                tag_states[tag_count] = it.st;
                tag_count++;
            end
        end
        else begin
            n = tag_count;
            if (n == 0)
                return;
            frame_xor = 8'h00;
            push_beat(cpdr_pkg::KIND_FRAME, cpdr_pkg::SYNC_BYTE, 16'h0000, 1'b0);
            push_beat(cpdr_pkg::KIND_FRAME, cpdr_pkg::PROTO_BYTE, 16'h0000, 1'b0);
            push_beat(cpdr_pkg::KIND_FRAME, 8'(n), 16'h0000, 1'b0);
            for (int b = 0; b < cpdr_pkg::BUCKETS; b++) begin
                for (int i = 0; i < n; i++) begin
                    if (int'(tag_ids[i][5:0]) % cpdr_pkg::BUCKETS == b) begin
                        push_beat(cpdr_pkg::KIND_FRAME, tag_states[i], 16'h0000, 1'b0);
                        push_beat(cpdr_pkg::KIND_FRAME, tag_ids[i][15:8], 16'h0000, 1'b0);
                        push_beat(cpdr_pkg::KIND_FRAME, tag_ids[i][7:0], 16'h0000, 1'b0);
                    end
                end
            end
            push_beat(cpdr_pkg::KIND_FRAME, frame_xor, 16'h0000, 1'b0);
            push_beat(cpdr_pkg::KIND_FRAME, cpdr_pkg::CR_BYTE, 16'h0000, 1'b0);
            push_beat(cpdr_pkg::KIND_FRAME, cpdr_pkg::LF_BYTE, 16'h0000, 1'b1);
            tag_count = 0;
        end
    endtask

    // driver: one beat at a time from tag_items, each after its own gap
    always @(negedge clk)
    begin : feeder
        tag_item_t nxt;
        logic      offer;
        int        feed_wait;
        if (rst_n) begin
            offer = s_axis_tvalid && !in_beat_taken;
            if (!offer && tag_items.size() > 0) begin
                if (feed_wait < tag_items[0].gap) begin
                    feed_wait++;
                end
                else begin
                    nxt       = tag_items.pop_front();
                    feed_wait = 0;
                    offer     = 1'b1;
                    s_axis_tdata <= {nxt.chk, nxt.rnd, nxt.st, nxt.id};
                    s_axis_tuser <= nxt.cmd;
                end
            end
            s_axis_tvalid <= offer;
        end
        else begin
            feed_wait = 0;
        end
    end

    // receiver: random wait before each beat, plus the long hold
    always @(negedge clk)
    begin : sink
        int rx_wait;
        if (rst_n) begin
            if (out_beat_taken)
                rx_wait = (out_seen % 64 < 16) ? 0 : int'($urandom_range(0, MAX_WAIT));
            if (rx_hold_on) begin
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
        else begin
            rx_wait = 0;
        end
    end

    // hold the output off long enough for the block to back up its input
    initial
    begin : rx_hold_proc
        while (items_accepted < HOLD_AFTER)
            @(negedge clk);
        rx_hold_on <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_on <= 1'b0;
    end

    // monitor: predict on input beats, check output beats, watchdog
    always @(posedge clk)
    begin : observer
        out_beat_t want;
        tag_item_t seen;
        in_beat_taken  = 1'b0;
        out_beat_taken = 1'b0;
        if (rst_n) begin
            in_beat_taken  = s_axis_tvalid && s_axis_tready;
            out_beat_taken = m_axis_tvalid && m_axis_tready;
            if (out_beat_taken) begin
                out_seen++;
                if (due_beats.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t unexpected beat: kind %0d data %02h id %04h last %0d",
                                 $realtime, m_axis_tuser, m_axis_tdata[7:0],
                                 m_axis_tdata[23:8], m_axis_tlast);
                end
                else begin
                    want = due_beats.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data ||
                        m_axis_tdata[23:8] !== want.rid || m_axis_tlast !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t exp/act kind %0d/%0d data %h/%h id %h/%h last %0d/%0d",
                                     $realtime, want.kind, m_axis_tuser, want.data,
                                     m_axis_tdata[7:0], want.rid, m_axis_tdata[23:8],
                                     want.last, m_axis_tlast);
                    end
                end
            end
            if (in_beat_taken) begin
                seen.cmd = s_axis_tuser;
                seen.id  = s_axis_tdata[15:0];
                seen.st  = s_axis_tdata[23:16];
                seen.rnd = s_axis_tdata[31:24];
                seen.chk = s_axis_tdata[39:32];
                seen.gap = 0;
                tag_table_step(seen);
                items_accepted++;
            end
            if (in_beat_taken || out_beat_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : main
        tag_item_t   it;
        logic [15:0] id_pool[32];
        int          npool;
        int          npkt;
        int          r;
        logic [7:0]  lo_pick;

        // directed: empty tick, field extremes, merge, bad packets
        queue_item(make_tick());
        queue_item(make_pkt(16'h0000, 8'h00, 8'h00));
        queue_item(make_pkt(16'hffff, 8'hf0, 8'h01));
        queue_item(make_pkt(16'hffff, 8'h0f, 8'h00));
        it = make_pkt(16'h5a5a, 8'h33, 8'h00);
        it.chk = ~it.chk;
        queue_item(it);
        queue_item(make_pkt(16'h1234, 8'h56, 8'h02));
        queue_item(make_pkt(16'habcd, 8'hff, 8'hff));
        // fill the table to capacity with colliding buckets, then overflow and merge
        for (int i = 0; i < 14; i++) begin
            lo_pick = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'h3f : 8'h95;
            queue_item(make_pkt({8'(i + 1), lo_pick}, 8'($urandom), 8'(i % 2)));
        end
        queue_item(make_pkt(16'h7777, 8'haa, 8'h01));
        queue_item(make_pkt(16'h0000, 8'h81, 8'h01));
        queue_item(make_tick());

        // random rounds: packets from a small id pool, then a tick
        while (items_total < RANDOM_ITEMS) begin
            npool = $urandom_range(1, 22);
            id_pool[0] = 16'($urandom);
            for (int j = 1; j < npool; j++) begin
                if ($urandom_range(0, 3) == 0)
                    id_pool[j] = (16'($urandom) & 16'hffc0) | (id_pool[0] & 16'h003f);
                else
                    id_pool[j] = 16'($urandom);
            end
            npkt = $urandom_range(1, 28);
            for (int k = 0; k < npkt; k++) begin
                r  = $urandom_range(0, 19);
                it = make_pkt(id_pool[$urandom_range(0, npool - 1)], 8'($urandom),
                              8'($urandom_range(0, 1)));
                if (r == 15 || r == 16) begin
                    it.chk = it.chk ^ 8'($urandom_range(1, 255));
                end
                else if (r > 16) begin
                    it = make_pkt(16'($urandom), 8'($urandom), 8'($urandom_range(2, 255)));
                    if ($urandom_range(0, 1) == 0)
                        it.chk = 8'($urandom);
                end
                queue_item(it);
            end
            queue_item(make_tick());
            if ($urandom_range(0, 7) == 0)
                queue_item(make_tick());
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total || due_beats.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_cnt == 0 && due_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
